/* rtl/sle_pkg.sv */
package sle_pkg;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// how the back end expands one string byte
	typedef enum logic [1:0] {
		CLS_PLAIN,
		CLS_LETTER,
		CLS_HEX
	} cls_t;

	// one classified request from front to back
	typedef struct packed {
		logic       open;
		logic       close;
		cls_t       cls;
		logic [7:0] data;
		logic       col;
	} desc_t;

	localparam int DESC_W = $bits(desc_t);

endpackage

/* rtl/sle_front.sv */
module sle_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               push,
	output logic               full,
	input  logic               kind,
	input  logic [7:0]         char_byte,
	output logic               q_wr,
	output sle_pkg::desc_t     q_wdata,
	input  logic               q_full
);

	logic colorize_q;
	logic open_q;
	logic accept;
	logic [7:0] letter;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_wr   = accept;

	// two-character escape letters
	always_comb begin
		case (char_byte)
			8'h07:   letter = 8'h61;
			8'h08:   letter = 8'h62;
			8'h1B:   letter = 8'h65;
			8'h0C:   letter = 8'h66;
			8'h0A:   letter = 8'h6E;
			8'h0D:   letter = 8'h72;
			8'h09:   letter = 8'h74;
			8'h0B:   letter = 8'h76;
			8'h22:   letter = 8'h22;
			8'h5C:   letter = 8'h5C;
			default: letter = 8'h00;
		endcase
	end

	// classify the request for the back end
	always_comb begin
		q_wdata.open  = !open_q;
		q_wdata.close = kind;
		q_wdata.col   = colorize_q;
		if (letter != 8'h00) begin
			q_wdata.cls  = sle_pkg::CLS_LETTER;
			q_wdata.data = letter;
		end else if (char_byte < 8'h20 || char_byte == 8'h7F) begin
			q_wdata.cls  = sle_pkg::CLS_HEX;
			q_wdata.data = char_byte;
		end else begin
			q_wdata.cls  = sle_pkg::CLS_PLAIN;
			q_wdata.data = char_byte;
		end
	end

	// color mode register and open-literal flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colorize_q <= 1'b0;
			open_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				colorize_q <= cfg_wdata;
			end
			if (accept) begin
				open_q <= !kind;
			end
		end
	end

endmodule

/* rtl/sle_queue.sv */
module sle_queue #(
	parameter int DEPTH = sle_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  sle_pkg::desc_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output sle_pkg::desc_t rd_data,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sle_pkg::desc_t entries_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr;
	logic           do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/sle_back.sv */
module sle_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sle_pkg::desc_t cur,
	input  logic           q_empty,
	output logic           q_rd,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     out_byte,
	output logic           run_last
);

	typedef enum logic [2:0] {
		PH_START,
		PH_OPEN,
		PH_HEAD,
		PH_BODY,
		PH_TAIL,
		PH_CLOSE
	} phase_t;

	phase_t     phase_q;
	logic [3:0] idx_q;
	logic       ob_valid_q;
	logic [7:0] ob_byte_q;
	logic       ob_last_q;

	phase_t     eff_ph;
	phase_t     nxt_ph;
	logic [3:0] eff_idx;
	logic [3:0] len;
	logic [7:0] byte_c;
	logic       phase_end;
	logic       item_end;
	logic       advance;

	// colored opening quote
	function automatic logic [7:0] open_col(input logic [3:0] i);
		case (i)
			4'd0:    return 8'h1B;
			4'd1:    return 8'h5B;
			4'd2:    return 8'h33;
			4'd3:    return 8'h35;
			4'd4:    return 8'h6D;
			default: return 8'h22;
		endcase
	endfunction

	// colored closing quote
	function automatic logic [7:0] close_col(input logic [3:0] i);
		case (i)
			4'd0:    return 8'h22;
			4'd1:    return 8'h1B;
			4'd2:    return 8'h5B;
			default: return 8'h6D;
		endcase
	endfunction

	// colored escape head, backslash in the middle
	function automatic logic [7:0] head_col(input logic [3:0] i);
		case (i)
			4'd0:    return 8'h1B;
			4'd1:    return 8'h5B;
			4'd2:    return 8'h33;
			4'd3:    return 8'h34;
			4'd4:    return 8'h6D;
			4'd5:    return 8'h5C;
			4'd6:    return 8'h1B;
			4'd7:    return 8'h5B;
			4'd8:    return 8'h31;
			default: return 8'h6D;
		endcase
	endfunction

	// colored escape tail
	function automatic logic [7:0] tail_col(input logic [3:0] i);
		case (i)
			4'd0:    return 8'h1B;
			4'd1:    return 8'h5B;
			4'd2:    return 8'h30;
			4'd3:    return 8'h3B;
			4'd4:    return 8'h33;
			4'd5:    return 8'h35;
			default: return 8'h6D;
		endcase
	endfunction

	// uppercase hex digit
	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
	endfunction

	assign advance  = !q_empty && (!ob_valid_q || pop);
	assign q_rd     = advance && item_end;
	assign empty    = !ob_valid_q;
	assign out_byte = ob_byte_q;
	assign run_last = ob_last_q;

	// current phase, first phase taken from the queue head
	always_comb begin
		if (phase_q == PH_START) begin
			eff_idx = 4'd0;
			if (cur.open) begin
				eff_ph = PH_OPEN;
			end else if (cur.close) begin
				eff_ph = PH_CLOSE;
			end else if (cur.cls == sle_pkg::CLS_PLAIN) begin
				eff_ph = PH_BODY;
			end else begin
				eff_ph = PH_HEAD;
			end
		end else begin
			eff_ph  = phase_q;
			eff_idx = idx_q;
		end
	end

	// byte generation and phase sequencing
	always_comb begin
		len      = 4'd1;
		byte_c   = 8'h00;
		nxt_ph   = PH_START;
		item_end = 1'b0;
		unique case (eff_ph)
			PH_OPEN: begin
				len    = cur.col ? 4'd6 : 4'd1;
				byte_c = cur.col ? open_col(eff_idx) : 8'h22;
				if (cur.close) begin
					nxt_ph = PH_CLOSE;
				end else if (cur.cls == sle_pkg::CLS_PLAIN) begin
					nxt_ph = PH_BODY;
				end else begin
					nxt_ph = PH_HEAD;
				end
			end
			PH_HEAD: begin
				len    = cur.col ? 4'd10 : 4'd1;
				byte_c = cur.col ? head_col(eff_idx) : 8'h5C;
				nxt_ph = PH_BODY;
			end
			PH_BODY: begin
				if (cur.cls == sle_pkg::CLS_HEX) begin
					len = 4'd3;
					case (eff_idx)
						4'd0:    byte_c = 8'h78;
						4'd1:    byte_c = hex_digit(cur.data[7:4]);
						default: byte_c = hex_digit(cur.data[3:0]);
					endcase
				end else begin
					byte_c = cur.data;
				end
				if (cur.cls != sle_pkg::CLS_PLAIN && cur.col) begin
					nxt_ph = PH_TAIL;
				end else begin
					item_end = (eff_idx == len - 4'd1);
				end
			end
			PH_TAIL: begin
				len      = 4'd7;
				byte_c   = tail_col(eff_idx);
				item_end = (eff_idx == len - 4'd1);
			end
			PH_CLOSE: begin
				len      = cur.col ? 4'd4 : 4'd1;
				byte_c   = cur.col ? close_col(eff_idx) : 8'h22;
				item_end = (eff_idx == len - 4'd1);
			end
			default: begin
				len    = 4'd1;
				byte_c = 8'h00;
			end
		endcase
		phase_end = (eff_idx == len - 4'd1);
	end

	// sequencer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			idx_q      <= 4'd0;
			ob_valid_q <= 1'b0;
			ob_byte_q  <= 8'h00;
			ob_last_q  <= 1'b0;
		end else begin
			if (advance) begin
				ob_valid_q <= 1'b1;
				ob_byte_q  <= byte_c;
				ob_last_q  <= item_end;
				if (item_end) begin
					phase_q <= PH_START;
					idx_q   <= 4'd0;
				end else if (phase_end) begin
					phase_q <= nxt_ph;
					idx_q   <= 4'd0;
				end else begin
					phase_q <= eff_ph;
					idx_q   <= eff_idx + 4'd1;
				end
			end else if (pop) begin
				ob_valid_q <= 1'b0;
			end
		end
	end

	// a request in progress keeps its queue entry
	a_busy_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_START) |-> !q_empty)
		else $error("sequencer busy with empty queue");

	// the tail only follows a colored escape
	a_tail_colored: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TAIL) |-> (cur.col && cur.cls != sle_pkg::CLS_PLAIN && !cur.close))
		else $error("escape tail on a request without colored escape");

	// the head only precedes an escape
	a_head_escape: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEAD) |-> (cur.cls != sle_pkg::CLS_PLAIN && !cur.close))
		else $error("escape head on a plain byte or end request");

	// index stays within the longest piece other than the escape head
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEAD) |-> (idx_q <= 4'd6))
		else $error("piece index out of range");

endmodule

/* rtl/string_literal_escaper.sv */
// String literal escaper.
// Input channel (push/full): one request per string byte (kind = 0) or one
// end-of-string request (kind = 1). A request is taken when push is high and
// full is low. Output channel (empty/pop): bytes of the quoted, escaped
// literal in order; run_last marks the last byte caused by one input request.
// cfg_we/cfg_wdata set the colorize mode; write it only while the block idles.
// An accepted request is queued before the back sequencer registers its first
// output byte. A front classifier writes a small queue; the back sequencer
// emits one byte per cycle from the queue head while the receiver pops, so a
// plain byte yields 1 byte, a letter escape 2 (18 colored), a hex escape 4
// (20 colored), plus 1 (6 colored) for the opening quote and 1 (4 colored)
// for the close. Sustained input rate is one request per cycle while output
// bytes stay at one per request and pops keep up; else the byte count sets it.
// When the receiver stalls, the output byte holds, the sequencer waits and
// the queue fills, after which full rises. Reset clears colorize, the open
// literal flag, the queue and the output register.
module string_literal_escaper #(
	parameter int QUEUE_DEPTH = sle_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       push,
	output logic       full,
	input  logic       kind,
	input  logic [7:0] char_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       run_last
);

	logic           q_wr;
	logic           q_rd;
	logic           q_full;
	logic           q_empty;
	sle_pkg::desc_t q_wdata;
	sle_pkg::desc_t q_rdata;

	// classifier and open-literal tracking
	sle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.char_byte (char_byte),
		.q_wr      (q_wr),
		.q_wdata   (q_wdata),
		.q_full    (q_full)
	);

	// decoupling queue
	sle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	// byte sequencer and output register
	sle_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cur      (q_rdata),
		.q_empty  (q_empty),
		.q_rd     (q_rd),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.run_last (run_last)
	);

endmodule
